// ===== rtl/kvi_pkg.sv =====
// Shared types, widths and codes of the keyframe vector interpolator.
// Used by the channel interfaces and the top level; depends on nothing.
package kvi_pkg;

  localparam int MAX_KEYS_DEF = 64;
  localparam int CMD_W        = 2;
  localparam int STAT_W       = 2;
  localparam int TIME_W       = 32;
  localparam int VAL_W        = 32;
  localparam int Q_BITS       = 34;
  localparam int KEY_W        = TIME_W + 3 * VAL_W;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef struct packed {
    logic [TIME_W-1:0] key_time;
    logic [VAL_W-1:0]  val_x;
    logic [VAL_W-1:0]  val_y;
    logic [VAL_W-1:0]  val_z;
  } key_t;

endpackage

// ===== rtl/kvi_if.sv =====
// Valid/ready channel interfaces for commands in and results out.
// Depends on kvi_pkg.
interface kvi_in_if;
  import kvi_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic [TIME_W-1:0]        key_or_query_time;
  logic signed [VAL_W-1:0]  value_x;
  logic signed [VAL_W-1:0]  value_y;
  logic signed [VAL_W-1:0]  value_z;

  modport source (output valid, command, key_or_query_time, value_x, value_y, value_z,
                  input ready);
  modport sink   (input valid, command, key_or_query_time, value_x, value_y, value_z,
                  output ready);
endinterface

interface kvi_out_if;
  import kvi_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [VAL_W-1:0]  result_x;
  logic signed [VAL_W-1:0]  result_y;
  logic signed [VAL_W-1:0]  result_z;

  modport source (output valid, status, result_x, result_y, result_z, input ready);
  modport sink   (input valid, status, result_x, result_y, result_z, output ready);
endinterface

// ===== rtl/kvi_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module kvi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/keyframe_vector_interpolator.sv =====
// Keyframe table with linear interpolation of a Q16.16 3-vector.
// Depends on kvi_pkg, kvi_in_if, kvi_out_if and kvi_ram.
//
// Usage: in_chan carries one command per transaction: clear the table,
// append a keyframe (time, x, y, z) or query the vector at a time. Every
// command gives exactly one transaction on out_chan with a status and a
// vector (zero unless a query succeeds).
// Keys sit in one RAM row each (time and vector), MAX_KEYS rows.
// Clear, append and a failed query go straight to the done state, from
// which the result moves into the output register. A query on more than
// one key scans the key times one RAM read per cycle; a query then reads
// the segment key and, to interpolate, the key after it, then runs each
// component through one shared 32x32 multiplier and a one-bit-per-cycle
// divider (skipped when the component saturates). in_chan.ready is high
// only while the sequencer is idle.
// The finished result sits in an output register; a new command is taken
// while out_chan is stalled, and its result waits until that one is taken.
// Reset empties the table (the key count goes to zero) and drops any
// pending result; no clearing pass over the RAM is needed.
module keyframe_vector_interpolator #(
  parameter int MAX_KEYS = kvi_pkg::MAX_KEYS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  kvi_in_if.sink     in_chan,
  kvi_out_if.source  out_chan
);
  import kvi_pkg::*;

  localparam int AW    = $clog2(MAX_KEYS);
  localparam int CW    = $clog2(MAX_KEYS + 1);
  localparam int BCW   = $clog2(Q_BITS);
  localparam int SUM_W = Q_BITS + 2;
  localparam int N_W   = 2 * VAL_W + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_RD0  = 4'd2;
  localparam logic [3:0] S_RD1  = 4'd3;
  localparam logic [3:0] S_RD2  = 4'd4;
  localparam logic [3:0] S_MUL  = 4'd5;
  localparam logic [3:0] S_PRE  = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0]                state_r, state_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [AW-1:0]             idx_r, idx_nxt;
  logic [AW-1:0]             seg_r, seg_nxt;
  logic                      interp_r, interp_nxt;
  logic [TIME_W-1:0]         t_r, t_nxt;
  logic [TIME_W-1:0]         t0_r, t0_nxt;
  logic [2:0][VAL_W-1:0]     v0_r, v0_nxt;
  logic [2:0][VAL_W-1:0]     v1_r, v1_nxt;
  logic [TIME_W-1:0]         n_r, n_nxt;
  logic [TIME_W-1:0]         d_r, d_nxt;
  logic                      sgn_r, sgn_nxt;
  logic                      neg_r, neg_nxt;
  logic [2*VAL_W-1:0]        prod_r, prod_nxt;
  logic [TIME_W-1:0]         rem_r, rem_nxt;
  logic [Q_BITS-1:0]         num_r, num_nxt;
  logic [Q_BITS-1:0]         q_r, q_nxt;
  logic [BCW-1:0]            bit_r, bit_nxt;
  logic                      sat_r, sat_nxt;
  logic [1:0]                comp_r, comp_nxt;
  logic [STAT_W-1:0]         stat_r, stat_nxt;
  logic [2:0][VAL_W-1:0]     res_r, res_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]         out_stat_r, out_stat_nxt;
  logic [2:0][VAL_W-1:0]     out_res_r, out_res_nxt;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [AW-1:0]             ram_raddr;
  logic [KEY_W-1:0]          ram_rdata;
  key_t                      wkey;
  key_t                      rkey;

  logic                      in_fire;
  logic [TIME_W:0]           dt_w;
  logic [TIME_W:0]           den_w;
  logic [VAL_W:0]            dv_w;
  logic [VAL_W-1:0]          mag_w;
  logic [N_W-1:0]            num_w;
  logic [VAL_W:0]            trial_w;
  logic                      ge_w;
  logic signed [SUM_W-1:0]   v0e_w;
  logic signed [SUM_W-1:0]   qe_w;
  logic signed [SUM_W-1:0]   sum_w;
  logic [SUM_W-VAL_W:0]      top_w;
  logic [VAL_W-1:0]          clamp_w;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;

  assign wkey = '{key_time: in_chan.key_or_query_time,
                  val_x:    in_chan.value_x,
                  val_y:    in_chan.value_y,
                  val_z:    in_chan.value_z};
  assign rkey = key_t'(ram_rdata);

  kvi_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_KEYS)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wkey),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_chan.valid    = out_valid_r;
  assign out_chan.status   = out_stat_r;
  assign out_chan.result_x = out_res_r[0];
  assign out_chan.result_y = out_res_r[1];
  assign out_chan.result_z = out_res_r[2];

  // shared datapath terms
  always_comb begin
    dt_w    = {1'b0, t_r} - {1'b0, t0_r};
    den_w   = {1'b0, rkey.key_time} - {1'b0, t0_r};
    dv_w    = {v1_r[comp_r][VAL_W-1], v1_r[comp_r]} - {v0_r[comp_r][VAL_W-1], v0_r[comp_r]};
    mag_w   = dv_w[VAL_W] ? VAL_W'(-dv_w) : dv_w[VAL_W-1:0];
    num_w   = {1'b0, prod_r} + N_W'(d_r >> 1);
    trial_w = {rem_r, num_r[Q_BITS-1]};
    ge_w    = (trial_w >= {1'b0, d_r});
    v0e_w   = SUM_W'(signed'(v0_r[comp_r]));
    qe_w    = signed'(SUM_W'(q_r));
    sum_w   = neg_r ? (v0e_w - qe_w) : (v0e_w + qe_w);
    top_w   = sum_w[SUM_W-1:VAL_W-1];
    if ((&top_w) || !(|top_w)) begin
      clamp_w = sum_w[VAL_W-1:0];
    end else begin
      clamp_w = sum_w[SUM_W-1] ? VAL_MIN : VAL_MAX;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    seg_nxt       = seg_r;
    interp_nxt    = interp_r;
    t_nxt         = t_r;
    t0_nxt        = t0_r;
    v0_nxt        = v0_r;
    v1_nxt        = v1_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    sgn_nxt       = sgn_r;
    neg_nxt       = neg_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    num_nxt       = num_r;
    q_nxt         = q_r;
    bit_nxt       = bit_r;
    sat_nxt       = sat_r;
    comp_nxt      = comp_r;
    stat_nxt      = stat_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_stat_nxt  = out_stat_r;
    out_res_nxt   = out_res_r;
    ram_we        = 1'b0;
    ram_waddr     = count_r[AW-1:0];
    ram_raddr     = seg_r;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          t_nxt    = in_chan.key_or_query_time;
          stat_nxt = ST_OK;
          res_nxt  = '0;
          state_nxt = S_DONE;
          case (in_chan.command)
            CMD_CLEAR: begin
              count_nxt = '0;
            end
            CMD_APPEND: begin
              if (count_r >= CW'(MAX_KEYS)) begin
                stat_nxt = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            CMD_QUERY: begin
              if (count_r == '0) begin
                stat_nxt = ST_EMPTY;
              end else if (count_r == CW'(1)) begin
                seg_nxt    = '0;
                interp_nxt = 1'b0;
                state_nxt  = S_RD0;
              end else begin
                ram_raddr = AW'(1);
                idx_nxt   = AW'(1);
                state_nxt = S_SCAN;
              end
            end
            default: begin
              stat_nxt = ST_OK;
            end
          endcase
        end
      end
      S_SCAN: begin
        ram_raddr = AW'(idx_r + AW'(1));
        if (rkey.key_time > t_r) begin
          seg_nxt    = AW'(idx_r - AW'(1));
          interp_nxt = 1'b1;
          state_nxt  = S_RD0;
        end else if ((CW'(idx_r) + CW'(1)) >= count_r) begin
          seg_nxt    = AW'(count_r - CW'(1));
          interp_nxt = 1'b0;
          state_nxt  = S_RD0;
        end else begin
          idx_nxt = AW'(idx_r + AW'(1));
        end
      end
      S_RD0: begin
        ram_raddr = seg_r;
        state_nxt = S_RD1;
      end
      S_RD1: begin
        ram_raddr = AW'(seg_r + AW'(1));
        t0_nxt    = rkey.key_time;
        v0_nxt    = {rkey.val_z, rkey.val_y, rkey.val_x};
        if (interp_r) begin
          state_nxt = S_RD2;
        end else begin
          res_nxt   = {rkey.val_z, rkey.val_y, rkey.val_x};
          state_nxt = S_DONE;
        end
      end
      S_RD2: begin
        v1_nxt = {rkey.val_z, rkey.val_y, rkey.val_x};
        if (rkey.key_time == t0_r) begin
          res_nxt   = v0_r;
          state_nxt = S_DONE;
        end else begin
          n_nxt     = dt_w[TIME_W] ? TIME_W'(-dt_w) : dt_w[TIME_W-1:0];
          d_nxt     = den_w[TIME_W] ? TIME_W'(-den_w) : den_w[TIME_W-1:0];
          sgn_nxt   = dt_w[TIME_W] ^ den_w[TIME_W];
          comp_nxt  = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = mag_w * n_r;
        neg_nxt   = dv_w[VAL_W] ^ sgn_r;
        state_nxt = S_PRE;
      end
      S_PRE: begin
        rem_nxt = TIME_W'(num_w[N_W-1:Q_BITS]);
        num_nxt = num_w[Q_BITS-1:0];
        q_nxt   = '0;
        bit_nxt = BCW'(Q_BITS - 1);
        sat_nxt = (TIME_W'(num_w[N_W-1:Q_BITS]) >= d_r);
        state_nxt = (TIME_W'(num_w[N_W-1:Q_BITS]) >= d_r) ? S_FIN : S_DIV;
      end
      S_DIV: begin
        rem_nxt = ge_w ? TIME_W'(trial_w - {1'b0, d_r}) : trial_w[TIME_W-1:0];
        q_nxt   = {q_r[Q_BITS-2:0], ge_w};
        num_nxt = {num_r[Q_BITS-2:0], 1'b0};
        bit_nxt = bit_r - BCW'(1);
        if (bit_r == '0) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (sat_r) begin
          res_nxt[comp_r] = neg_r ? VAL_MIN : VAL_MAX;
        end else begin
          res_nxt[comp_r] = clamp_w;
        end
        if (comp_r == 2'd2) begin
          state_nxt = S_DONE;
        end else begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = S_MUL;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = stat_r;
          out_res_nxt   = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    seg_r      <= seg_nxt;
    interp_r   <= interp_nxt;
    t_r        <= t_nxt;
    t0_r       <= t0_nxt;
    v0_r       <= v0_nxt;
    v1_r       <= v1_nxt;
    n_r        <= n_nxt;
    d_r        <= d_nxt;
    sgn_r      <= sgn_nxt;
    neg_r      <= neg_nxt;
    prod_r     <= prod_nxt;
    rem_r      <= rem_nxt;
    num_r      <= num_nxt;
    q_r        <= q_nxt;
    bit_r      <= bit_nxt;
    sat_r      <= sat_nxt;
    comp_r     <= comp_nxt;
    stat_r     <= stat_nxt;
    res_r      <= res_nxt;
    out_stat_r <= out_stat_nxt;
    out_res_r  <= out_res_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_KEYS))
    else $error("key count beyond table depth");

  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_chan.command == CMD_APPEND && count_r < CW'(MAX_KEYS))
    |=> (count_r == $past(count_r) + CW'(1)))
    else $error("append did not advance key count");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < d_r))
    else $error("divider remainder not below divisor");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_chan.ready) |=> (state_r == S_DONE))
    else $error("result left sequencer while output stalled");

endmodule

// ===== tb/kvi_result_check.sv =====
// Result checker for the keyframe vector interpolator: mirrors the key table,
// predicts the status and vector of every command and compares transactions in order.
// Depends on kvi_pkg, kvi_in_if and kvi_out_if.
module kvi_result_check #(
  parameter int MAX_KEYS = kvi_pkg::MAX_KEYS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  kvi_in_if    in_mon,
  kvi_out_if   out_mon,
  output int   results_seen,
  output int   mismatches,
  output int   awaiting,
  output int   lerp_queries,
  output int   empty_queries,
  output int   full_appends
);
  timeunit 1ns;
  timeprecision 1ps;
  import kvi_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  x;
    logic [VAL_W-1:0]  y;
    logic [VAL_W-1:0]  z;
  } vec_result_t;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  logic [TIME_W-1:0] key_time_tbl [MAX_KEYS];
  logic [VAL_W-1:0]  key_x_tbl    [MAX_KEYS];
  logic [VAL_W-1:0]  key_y_tbl    [MAX_KEYS];
  logic [VAL_W-1:0]  key_z_tbl    [MAX_KEYS];
  int                key_total;

  vec_result_t awaited_vectors [$];
  vec_result_t want;
  int          n_seen, n_bad, n_lerp, n_empty, n_full;

  // a + (b - a) * dt / den, rounded half away from zero, saturated
  function automatic logic [VAL_W-1:0] blend_component(input logic [VAL_W-1:0] a,
                                                       input logic [VAL_W-1:0] b,
                                                       input longint dt, input longint den);
    longint          v0, dv, q, res;
    longint unsigned m, n, d, qa, r, hi, lo;
    bit              neg;
    v0  = $signed({{32{a[VAL_W-1]}}, a});
    dv  = $signed({{32{b[VAL_W-1]}}, b}) - v0;
    neg = ((dv < 0) != (dt < 0)) != (den < 0);
    m   = (dv < 0) ? -dv : dv;
    n   = (dt < 0) ? -dt : dt;
    d   = (den < 0) ? -den : den;
    qa  = n / d;
    r   = n % d;
    hi  = m * qa;
    lo  = (m * r + d / 2) / d;
    if (hi > (64'd1 << 40)) begin
      res = neg ? SAT_LO : SAT_HI;
    end else begin
      q   = longint'(hi + lo);
      res = neg ? v0 - q : v0 + q;
    end
    if (res > SAT_HI) res = SAT_HI;
    if (res < SAT_LO) res = SAT_LO;
    return res[VAL_W-1:0];
  endfunction

  function automatic vec_result_t step_keyframes(input logic [CMD_W-1:0]  cmd,
                                                 input logic [TIME_W-1:0] t,
                                                 input logic [VAL_W-1:0]  vx,
                                                 input logic [VAL_W-1:0]  vy,
                                                 input logic [VAL_W-1:0]  vz);
    vec_result_t res;
    int          seg, j;
    bit          hit;
    longint      dt, den;
    res = '0;
    case (cmd)
      CMD_CLEAR: key_total = 0;
      CMD_APPEND: begin
        if (key_total >= MAX_KEYS) begin
          res.status = ST_FULL;
          n_full++;
        end else begin
          key_time_tbl[key_total] = t;
          key_x_tbl[key_total]    = vx;
          key_y_tbl[key_total]    = vy;
          key_z_tbl[key_total]    = vz;
          key_total++;
        end
      end
      CMD_QUERY: begin
        if (key_total == 0) begin
          res.status = ST_EMPTY;
          n_empty++;
        end else begin
          seg = key_total - 1;
          hit = 1'b0;
          for (j = 0; j + 1 < key_total; j++) begin
            if (!hit && key_time_tbl[j + 1] > t) begin
              seg = j;
              hit = 1'b1;
            end
          end
          den = 0;
          if (seg + 1 < key_total)
            den = {32'd0, key_time_tbl[seg + 1]} - {32'd0, key_time_tbl[seg]};
          if (den == 0) begin
            res.x = key_x_tbl[seg];
            res.y = key_y_tbl[seg];
            res.z = key_z_tbl[seg];
          end else begin
            dt    = {32'd0, t} - {32'd0, key_time_tbl[seg]};
            res.x = blend_component(key_x_tbl[seg], key_x_tbl[seg + 1], dt, den);
            res.y = blend_component(key_y_tbl[seg], key_y_tbl[seg + 1], dt, den);
            res.z = blend_component(key_z_tbl[seg], key_z_tbl[seg + 1], dt, den);
            n_lerp++;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      key_total = 0;
      awaited_vectors.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        n_seen++;
        if (awaited_vectors.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("%0t: unexpected result st=%0d x=%h y=%h z=%h", $time, out_mon.status,
                     out_mon.result_x, out_mon.result_y, out_mon.result_z);
        end else begin
          want = awaited_vectors.pop_front();
          if (out_mon.status !== want.status || out_mon.result_x !== want.x ||
              out_mon.result_y !== want.y || out_mon.result_z !== want.z) begin
            n_bad++;
            if (n_bad <= 10)
              $display("%0t: mismatch, expected st=%0d x=%h y=%h z=%h, got st=%0d x=%h y=%h z=%h",
                       $time, want.status, want.x, want.y, want.z, out_mon.status,
                       out_mon.result_x, out_mon.result_y, out_mon.result_z);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        awaited_vectors.insert(awaited_vectors.size(),
                               step_keyframes(in_mon.command, in_mon.key_or_query_time,
                                              in_mon.value_x, in_mon.value_y,
                                              in_mon.value_z));
    end
    results_seen  <= n_seen;
    mismatches    <= n_bad;
    awaiting      <= awaited_vectors.size();
    lerp_queries  <= n_lerp;
    empty_queries <= n_empty;
    full_appends  <= n_full;
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the keyframe vector interpolator testbench: clock, reset, command stimulus,
// result back-pressure and the verdict. Depends on kvi_pkg, the channel interfaces,
// keyframe_vector_interpolator and kvi_result_check.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import kvi_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
  localparam int ITEM_TARGET  = 1100;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 250;
  localparam int CYCLE_LIMIT  = 1_500_000;

  logic              clk;
  logic              rst_n;
  logic              long_hold;
  int                send_pct;
  int                recv_pct;
  int                hold_cnt;
  int                cycle_cnt;
  int                items_sent;
  int                directed_items;
  int                clip_no;
  logic [TIME_W-1:0] table_times [$];

  int results_seen, mismatches, awaiting, lerp_queries, empty_queries, full_appends;

  kvi_in_if  in_chan ();
  kvi_out_if out_chan ();

  keyframe_vector_interpolator DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  kvi_result_check vector_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .results_seen  (results_seen),
    .mismatches    (mismatches),
    .awaiting      (awaiting),
    .lerp_queries  (lerp_queries),
    .empty_queries (empty_queries),
    .full_appends  (full_appends)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    out_chan.ready = 1'b0;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (long_hold && hold_cnt < HOLD_CYCLES) begin
        out_chan.ready <= 1'b0;
        hold_cnt++;
      end else begin
        if (!long_hold) hold_cnt = 0;
        out_chan.ready <= $urandom_range(99) >= recv_pct;
      end
    end
  end

  task automatic offer(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] t,
                       input logic [VAL_W-1:0] vx, input logic [VAL_W-1:0] vy,
                       input logic [VAL_W-1:0] vz);
    while ($urandom_range(99) < send_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid             <= 1'b1;
    in_chan.command           <= cmd;
    in_chan.key_or_query_time <= t;
    in_chan.value_x           <= vx;
    in_chan.value_y           <= vy;
    in_chan.value_z           <= vz;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    items_sent++;
    if (cmd == CMD_CLEAR) table_times.delete();
    else if (cmd == CMD_APPEND && table_times.size() < MAX_KEYS_DEF)
      table_times.insert(table_times.size(), t);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(7))
      0, 1:    return $urandom;
      2:       return VAL_MAX;
      3:       return VAL_MIN;
      4:       return '0;
      default: return $urandom_range(32'h000F_FFFF) - 32'h0008_0000;
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_query_time();
    logic [TIME_W-1:0] base;
    if (table_times.size() == 0) return $urandom;
    base = table_times[$urandom_range(table_times.size() - 1)];
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return base;
      4:       return base - $urandom_range(32'h0002_0000);
      9:       return $urandom;
      default: return base + $urandom_range(32'h0002_0000);
    endcase
  endfunction

  // clear (optionally), append keys in mostly rising time order, then sample the curve
  task automatic run_clip(input int n_keys, input int n_queries, input bit fresh);
    logic [TIME_W-1:0] t;
    if (fresh) offer(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
    if (table_times.size() > 0) begin
      t = table_times[table_times.size() - 1];
    end else begin
      case ($urandom_range(3))
        0:       t = '0;
        1:       t = $urandom;
        default: t = $urandom_range(32'h0010_0000);
      endcase
    end
    repeat (n_keys) begin
      case ($urandom_range(19))
        0:       t = $urandom;
        1:       ;
        2:       t = t + $urandom;
        default: t = t + $urandom_range(32'h0004_0000, 1);
      endcase
      offer(CMD_APPEND, t, pick_value(), pick_value(), pick_value());
    end
    repeat (n_queries) offer(CMD_QUERY, pick_query_time(), $urandom, $urandom, $urandom);
  endtask

  initial begin
    int phase;
    int n_keys;
    rst_n                     = 1'b0;
    long_hold                 = 1'b0;
    send_pct                  = 0;
    in_chan.valid             = 1'b0;
    in_chan.command           = CMD_CLEAR;
    in_chan.key_or_query_time = '0;
    in_chan.value_x           = '0;
    in_chan.value_y           = '0;
    in_chan.value_z           = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    offer(CMD_QUERY, '0, $urandom, $urandom, $urandom);
    offer(CMD_NOP, $urandom, $urandom, $urandom, $urandom);
    offer(CMD_APPEND, 32'h0001_0000, VAL_MAX, VAL_MIN, '0);
    offer(CMD_QUERY, 32'h1234_5678, $urandom, $urandom, $urandom);
    offer(CMD_APPEND, 32'h0003_0000, VAL_MIN, VAL_MAX, 32'h0001_0000);
    offer(CMD_QUERY, 32'h0002_0000, $urandom, $urandom, $urandom);
    offer(CMD_QUERY, '0, $urandom, $urandom, $urandom);
    offer(CMD_QUERY, 32'h0001_0000, $urandom, $urandom, $urandom);
    offer(CMD_QUERY, 32'h0003_0000, $urandom, $urandom, $urandom);
    offer(CMD_QUERY, '1, $urandom, $urandom, $urandom);
    offer(CMD_QUERY, 32'h0002_4000, $urandom, $urandom, $urandom);
    offer(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
    offer(CMD_QUERY, '0, $urandom, $urandom, $urandom);
    offer(CMD_APPEND, 32'd5, 32'h0001_0000, '1, VAL_MAX);
    offer(CMD_APPEND, 32'd5, 32'd7, 32'd8, 32'd9);
    offer(CMD_QUERY, 32'd2, $urandom, $urandom, $urandom);
    offer(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
    offer(CMD_APPEND, 32'hFFFF_FFFE, VAL_MAX, VAL_MIN, 32'h0000_0100);
    offer(CMD_APPEND, 32'hFFFF_FFFF, VAL_MIN, VAL_MAX, 32'hFFFF_FF00);
    offer(CMD_QUERY, '0, $urandom, $urandom, $urandom);
    offer(CMD_APPEND, 32'h0000_1000, 32'h0002_0000, 32'hFFFE_0000, '0);
    offer(CMD_QUERY, 32'h0000_0800, $urandom, $urandom, $urandom);
    offer(CMD_QUERY, '1, $urandom, $urandom, $urandom);
    offer(CMD_NOP, '1, '1, '1, '1);
    directed_items = items_sent;

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_pct = 0;
          recv_pct <= 0;
        end
        1: begin
          send_pct = 84;
          recv_pct <= 0;
        end
        2: begin
          send_pct = 0;
          recv_pct <= 84;
        end
        default: begin
          send_pct = 16;
          recv_pct <= 16;
        end
      endcase
      if (phase == 0) begin
        long_hold <= 1'b1;
        run_clip(3, 8, 1'b1);
        long_hold <= 1'b0;
      end
      while (items_sent < directed_items + (phase + 1) * ITEM_TARGET / 4) begin
        clip_no++;
        if (clip_no % 40 == 1) begin
          run_clip(MAX_KEYS_DEF + 2, 4, 1'b1);
        end else begin
          case ($urandom_range(9))
            9:       n_keys = 0;
            7, 8:    n_keys = $urandom_range(20, 7);
            default: n_keys = $urandom_range(6, 1);
          endcase
          run_clip(n_keys, $urandom_range(6, 1), $urandom_range(7) != 0);
        end
        if ($urandom_range(3) == 0)
          offer(CMD_W'($urandom_range(CMD_NOP)), $urandom, pick_value(), pick_value(),
                pick_value());
      end
    end

    in_chan.valid <= 1'b0;
    while (results_seen < items_sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d commands (%0d directed) over four idling mixes and a %0d-cycle stall",
             items_sent, directed_items, HOLD_CYCLES);
    $display("%0d interpolated queries, %0d queries on an empty table, %0d refused appends",
             lerp_queries, empty_queries, full_appends);
    if (mismatches == 0 && awaiting == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/kvi_pkg.sv
rtl/kvi_if.sv
rtl/kvi_ram.sv
rtl/keyframe_vector_interpolator.sv
tb/kvi_result_check.sv
tb/testbench.sv
